[src/brbc_pkg.sv]
// Shared types, constants and helpers of the chunked byte ring buffer.
package brbc_pkg;

  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned MAX_CHUNK_DEF = 64;
  localparam int unsigned QDEPTH        = 4;
  localparam logic [10:0] CAP_RESET     = 11'd1024;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_ENQ   = 3'd1,
    MODE_DEQ   = 3'd2,
    MODE_PEEK  = 3'd3,
    MODE_DROP  = 3'd4
  } mode_e;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic [6:0] chunk_length;
    logic       partial;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  count;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [10:0] fill_level;
    logic [10:0] free_space;
  } out_item_t;

  // Command from the front to the back; the ring address travels beside it.
  typedef struct packed {
    logic        wr;
    logic        res;
    logic        run;
    logic [7:0]  data;
    logic [6:0]  count;
    logic [10:0] fill;
    logic [10:0] free;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [10:0] free_of(logic [10:0] cap, logic [10:0] held);
    free_of = (cap > held) ? (cap - held) : 11'd0;
  endfunction

endpackage

[src/brbc_front.sv]
// Front end: accepts items, keeps pointers and chunk state, issues commands.
module brbc_front import brbc_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_CHUNK = MAX_CHUNK_DEF,
  localparam int unsigned AW       = $clog2(DEPTH),
  localparam int unsigned CW       = ((AW > 11) ? AW : 11) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [10:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_data_i,
  input  q_status_t     q_status_i,
  output logic          push_o,
  output cmd_t          push_cmd_o,
  output logic [AW-1:0] push_addr_o,
  output logic [10:0]   cap_o
);

  logic [10:0]   cap_q;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [10:0]   held_q, held_d;
  logic [6:0]    acc_q, acc_d;
  logic [6:0]    tot_q, tot_d;
  logic [6:0]    pos_q, pos_d;

  logic [10:0]   cap;
  logic          accept;
  logic [6:0]    len;
  logic [6:0]    acc_s;
  logic [6:0]    acc_e, tot_e, pos_e;
  logic          open;
  logic          part_e;
  logic [6:0]    n;
  logic [CW-1:0] wr_inc, rd_sum;
  logic [AW-1:0] wr_adv, rd_adv;
  cmd_t          cmd;
  logic [AW-1:0] addr;

  assign cap = (CW'(cap_q) > CW'(DEPTH)) ? 11'(DEPTH) : cap_q;
  assign cap_o = cap;
  assign in_ready_o = !q_status_i.full;
  assign accept = in_valid_i && in_ready_o;

  assign len = (in_data_i.chunk_length > 7'(MAX_CHUNK)) ? 7'(MAX_CHUNK)
                                                        : in_data_i.chunk_length;

  // Accepted count for a new chunk: refuse whole or cut to free space.
  always_comb begin
    acc_s = 7'd0;
    if (cap != 11'd0) begin
      if (({5'd0, len} + {1'b0, held_q}) > {1'b0, cap}) begin
        acc_s = in_data_i.partial ? 7'(cap - held_q) : 7'd0;
      end else begin
        acc_s = len;
      end
    end
  end

  // Read length: drop is always partial.
  assign part_e = in_data_i.partial || (in_data_i.mode == MODE_DROP);
  always_comb begin
    n = 7'd0;
    if (cap != 11'd0 && held_q != 11'd0) begin
      if ({4'd0, len} > held_q) begin
        n = part_e ? 7'(held_q) : 7'd0;
      end else begin
        n = len;
      end
    end
  end

  assign wr_inc = CW'(wr_idx_q) + CW'(1);
  assign wr_adv = (wr_inc >= CW'(cap)) ? '0 : AW'(wr_inc);
  assign rd_sum = CW'(rd_idx_q) + CW'(n);
  assign rd_adv = (rd_sum >= CW'(cap)) ? AW'(rd_sum - CW'(cap)) : AW'(rd_sum);

  always_comb begin
    acc_e = acc_q;
    tot_e = tot_q;
    pos_e = pos_q;
    open  = pos_q < tot_q;
    if (in_data_i.chunk_start) begin
      acc_e = acc_s;
      tot_e = len;
      pos_e = 7'd0;
      open  = 1'b1;
    end
  end

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    held_d   = held_q;
    acc_d    = acc_q;
    tot_d    = tot_q;
    pos_d    = pos_q;
    cmd      = '0;
    addr     = '0;
    if (accept) begin
      unique case (in_data_i.mode)
        MODE_ENQ: begin
          if (in_data_i.chunk_start && len == 7'd0) begin
            acc_d   = acc_s;
            tot_d   = 7'd0;
            pos_d   = 7'd0;
            cmd.res = 1'b1;
          end else if (open) begin
            acc_d = acc_e;
            tot_d = tot_e;
            pos_d = pos_e + 7'd1;
            if (pos_e < acc_e) begin
              cmd.wr   = 1'b1;
              cmd.data = in_data_i.data_byte;
              addr     = wr_idx_q;
              wr_idx_d = wr_adv;
              held_d   = held_q + 11'd1;
            end
            if ((pos_e + 7'd1) >= tot_e) begin
              cmd.res   = 1'b1;
              cmd.count = acc_e;
            end
          end
        end
        MODE_CLEAR: begin
          acc_d    = 7'd0;
          tot_d    = 7'd0;
          pos_d    = 7'd0;
          wr_idx_d = '0;
          rd_idx_d = '0;
          held_d   = 11'd0;
          cmd.res  = 1'b1;
        end
        MODE_DEQ, MODE_PEEK, MODE_DROP: begin
          acc_d = 7'd0;
          tot_d = 7'd0;
          pos_d = 7'd0;
          if (in_data_i.mode != MODE_PEEK) begin
            rd_idx_d = rd_adv;
            held_d   = held_q - 11'(n);
          end
          cmd.count = n;
          if (in_data_i.mode == MODE_DROP || n == 7'd0) begin
            cmd.res = 1'b1;
          end else begin
            cmd.run = 1'b1;
            addr    = rd_idx_q;
          end
        end
        default: begin
          // Undefined modes leave everything as is.
        end
      endcase
    end
    cmd.fill = held_d;
    cmd.free = free_of(cap, held_d);
  end

  assign push_o      = cmd.wr || cmd.res || cmd.run;
  assign push_cmd_o  = cmd;
  assign push_addr_o = addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      held_q   <= 11'd0;
      acc_q    <= 7'd0;
      tot_q    <= 7'd0;
      pos_q    <= 7'd0;
    end else if (cfg_we_i) begin
      // New capacity empties the ring and closes any chunk.
      cap_q    <= cfg_data_i;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      held_q   <= 11'd0;
      acc_q    <= 7'd0;
      tot_q    <= 7'd0;
      pos_q    <= 7'd0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      held_q   <= held_d;
      acc_q    <= acc_d;
      tot_q    <= tot_d;
      pos_q    <= pos_d;
    end
  end

endmodule

[src/brbc_cmd_queue.sv]
// Short command queue between the front end and the back end.
module brbc_cmd_queue import brbc_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_cmd_i,
  input  logic [AW-1:0] push_addr_i,
  input  logic          pop_i,
  output cmd_t          head_cmd_o,
  output logic [AW-1:0] head_addr_o,
  output q_status_t     status_o
);

  localparam int unsigned PW = $clog2(QDEPTH);

  cmd_t          cmd_q  [QDEPTH];
  logic [AW-1:0] addr_q [QDEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign status_o.full  = (cnt_q == (PW+1)'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign head_cmd_o  = cmd_q[rptr_q];
  assign head_addr_o = addr_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wptr_q]  <= push_cmd_i;
      addr_q[wptr_q] <= push_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

[src/brbc_back.sv]
// Back end: ring memory, read runs and the registered result stage.
module brbc_back import brbc_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = ((AW > 11) ? AW : 11) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [10:0]   cap_i,
  input  q_status_t     q_status_i,
  input  cmd_t          head_cmd_i,
  input  logic [AW-1:0] head_addr_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_item_t     out_data_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;

  back_state_e   state_q, state_d;
  logic [AW-1:0] p_q, p_d;
  logic [6:0]    left_q, left_d;
  cmd_t          run_q, run_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;
  logic          slot_free;
  logic          mem_we;
  logic [CW-1:0] p_inc;
  logic [AW-1:0] p_adv;

  assign slot_free = !out_valid_q || out_ready_i;
  assign p_inc = CW'(p_q) + CW'(1);
  assign p_adv = (p_inc >= CW'(cap_i)) ? '0 : AW'(p_inc);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty && head_cmd_i.run) begin
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (slot_free && left_q == 7'd1) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    p_d         = p_q;
    left_d      = left_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty) begin
          if (head_cmd_i.run) begin
            pop_o  = 1'b1;
            p_d    = head_addr_i;
            left_d = head_cmd_i.count;
            run_d  = head_cmd_i;
          end else if (!head_cmd_i.res || slot_free) begin
            pop_o  = 1'b1;
            mem_we = head_cmd_i.wr;
            if (head_cmd_i.res) begin
              out_valid_d      = 1'b1;
              out_d.count      = head_cmd_i.count;
              out_d.out_byte   = 8'd0;
              out_d.byte_valid = 1'b0;
              out_d.last       = 1'b1;
              out_d.fill_level = head_cmd_i.fill;
              out_d.free_space = head_cmd_i.free;
            end
          end
        end
      end
      B_RUN: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.count      = run_q.count;
          out_d.out_byte   = rdata_q;
          out_d.byte_valid = 1'b1;
          out_d.last       = (left_q == 7'd1);
          out_d.fill_level = run_q.fill;
          out_d.free_space = run_q.free;
          left_d           = left_q - 7'd1;
          p_d              = p_adv;
        end
      end
      default: begin
      end
    endcase
  end

  // Read data always tracks the byte at the next run address.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[head_addr_i] <= head_cmd_i.data;
    end
    rdata_q <= mem[p_d];
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    left_q <= left_d;
    run_q  <= run_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/byte_ring_buffer_chunked_top.sv]
// Top level of the chunked byte ring buffer.
//
// Usage: items enter on the in channel (in_valid_i/in_ready_o, in_data_i), one
// beat per item; result beats leave on the out channel (out_valid_o/
// out_ready_i, out_data_o). The capacity register is written on the cfg
// channel, which is always ready; write it only while the block is idle.
// Order: a single result beat (chunk count, clear, drop, refused or empty
// read) passes through the command queue, then the back end pops the
// command and loads the output register. The first byte of a dequeue or
// peek run also passes through the registered ring read.
// Throughput: the front end takes one item per cycle while the four-entry
// command queue has room; enqueue bytes stream at one per cycle while no run
// or stalled result holds the back end. A run of n bytes holds the back end
// while it pops the command and addresses the ring, then one beat per byte.
// Reset: ring empty, pointers and fill count zero, capacity 1024. The ring
// memory itself is not cleared; only written bytes are ever read back.
// Stall: when out_ready_i is low the output register holds its beat, the
// back end stops at the next result, the queue fills and in_ready_o drops.
module byte_ring_buffer_chunked_top import brbc_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          push;
  cmd_t          push_cmd;
  logic [AW-1:0] push_addr;
  logic          pop;
  cmd_t          head_cmd;
  logic [AW-1:0] head_addr;
  q_status_t     q_status;
  logic [10:0]   cap;

  // Capacity writes are always accepted; never stall them.
  assign cfg_ready_o = 1'b1;

  brbc_front #(
    .DEPTH     (DEPTH),
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_addr_o (push_addr),
    .cap_o       (cap)
  );

  // Decouple classification from memory access and result delivery.
  brbc_cmd_queue #(
    .AW (AW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .push_addr_i (push_addr),
    .pop_i       (pop),
    .head_cmd_o  (head_cmd),
    .head_addr_o (head_addr),
    .status_o    (q_status)
  );

  brbc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap),
    .q_status_i  (q_status),
    .head_cmd_i  (head_cmd),
    .head_addr_i (head_addr),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/brbc_checker.sv]
// Port-level checker for the chunked byte ring buffer, bound to the top level.
module brbc_checker import brbc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [10:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // A beat without a byte is always a single, final result.
  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.last)
    else $error("byte-less result beat not marked last");

  // A byte beat belongs to a run with a nonzero count.
  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |-> out_data_o.count != 7'd0)
    else $error("byte beat with zero count");

  // Within a run the next beat continues with the same count.
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.byte_valid && !out_data_o.last
    |=> !out_valid_o
        || (out_data_o.byte_valid && out_data_o.count == $past(out_data_o.count)))
    else $error("read run broken");

endmodule

bind byte_ring_buffer_chunked_top brbc_checker u_brbc_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the chunked byte ring buffer, with scoreboard and stimulus.
module tb;
  import brbc_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 200;  // long receiver hold-off, in cycles
  localparam int unsigned SETTLE_CYCLES = 16;   // queue depth plus pipeline, with margin
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned IDLE_PCT      = 8;

  // Mode codes that the block must ignore.
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  // Predict result beats of the ring and check the beats that leave the block.
  class ring_scoreboard;
    logic [7:0]  ring_mem [DEPTH_DEF];
    int unsigned wr_ptr, rd_ptr, held;
    int unsigned chunk_ok, chunk_len, chunk_pos;
    logic [10:0] capacity = CAP_RESET;
    out_item_t   expected_beats [$];
    int unsigned fails;

    function int unsigned live_cap();
      return (capacity > DEPTH_DEF) ? DEPTH_DEF : int'(capacity);
    endfunction

    function int unsigned wrap_inc(int unsigned idx, int unsigned cap);
      return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function void add_beat(int unsigned cnt, logic [7:0] b, logic vld, logic lst);
      out_item_t   o;
      int unsigned cap;
      cap          = live_cap();
      o.count      = cnt[6:0];
      o.out_byte   = b;
      o.byte_valid = vld;
      o.last       = lst;
      o.fill_level = held[10:0];
      o.free_space = (cap > held) ? 11'(cap - held) : 11'd0;
      expected_beats.push_back(o);
    endfunction

    // A capacity write empties the ring and closes any open chunk.
    function void configure(logic [10:0] v);
      capacity  = v;
      wr_ptr    = 0;
      rd_ptr    = 0;
      held      = 0;
      chunk_ok  = 0;
      chunk_len = 0;
      chunk_pos = 0;
    endfunction

    function void note_item(in_item_t it);
      logic [2:0]  m;
      logic        part;
      int unsigned cap, len, n, p;
      m    = it.mode;
      part = it.partial;
      cap  = live_cap();
      len  = (it.chunk_length > MAX_CHUNK_DEF) ? MAX_CHUNK_DEF : int'(it.chunk_length);
      if (m > MODE_DROP) return;

      if (m == MODE_ENQ) begin
        if (it.chunk_start) begin
          chunk_ok = 0;
          if (cap != 0) chunk_ok = (len + held > cap) ? (part ? cap - held : 0) : len;
          chunk_len = len;
          chunk_pos = 0;
          if (len == 0) begin
            add_beat(0, 8'h00, 1'b0, 1'b1);
            return;
          end
        end else if (chunk_pos >= chunk_len) begin
          return;
        end
        if (chunk_pos < chunk_ok) begin
          ring_mem[wr_ptr] = it.data_byte;
          wr_ptr = wrap_inc(wr_ptr, cap);
          held++;
        end
        chunk_pos++;
        if (chunk_pos >= chunk_len) add_beat(chunk_ok, 8'h00, 1'b0, 1'b1);
        return;
      end

      // Any other mode closes an open chunk without a result.
      chunk_ok  = 0;
      chunk_len = 0;
      chunk_pos = 0;

      if (m == MODE_CLEAR) begin
        wr_ptr = 0;
        rd_ptr = 0;
        held   = 0;
        add_beat(0, 8'h00, 1'b0, 1'b1);
        return;
      end

      if (m == MODE_DROP) part = 1'b1;
      n = 0;
      if (cap != 0 && held != 0) n = (len > held) ? (part ? held : 0) : len;

      p = rd_ptr;
      if (m != MODE_PEEK) begin
        for (int i = 0; i < n; i++) rd_ptr = wrap_inc(rd_ptr, cap);
        held -= n;
      end

      if (m == MODE_DROP || n == 0) begin
        add_beat(n, 8'h00, 1'b0, 1'b1);
        return;
      end
      for (int i = 0; i < n; i++) begin
        add_beat(n, ring_mem[p], 1'b1, i + 1 == n);
        p = wrap_inc(p, cap);
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      logic      bad;
      if (expected_beats.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: unexpected beat count %0d byte %02h valid %b last %b fill %0d free %0d",
                   $realtime, got.count, got.out_byte, got.byte_valid, got.last,
                   got.fill_level, got.free_space);
        return;
      end
      want = expected_beats.pop_front();
      bad  = (got.count      !== want.count)      || (got.out_byte   !== want.out_byte)   ||
             (got.byte_valid !== want.byte_valid) || (got.last       !== want.last)       ||
             (got.fill_level !== want.fill_level) || (got.free_space !== want.free_space);
      if (bad) begin
        fails++;
        if (fails <= MAX_REPORTS) begin
          $display("%0t: beat mismatch", $realtime);
          $display("  expected count %0d byte %02h valid %b last %b fill %0d free %0d",
                   want.count, want.out_byte, want.byte_valid, want.last,
                   want.fill_level, want.free_space);
          $display("  actual   count %0d byte %02h valid %b last %b fill %0d free %0d",
                   got.count, got.out_byte, got.byte_valid, got.last,
                   got.fill_level, got.free_space);
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  ring_scoreboard sb = new();

  // Shared knobs between stimulus and the result sink.
  logic        steady       = 1'b0;  // suppress random idling on both sides
  int unsigned holdoff_asks = 0;
  int unsigned holdoff_done = 0;

  byte_ring_buffer_chunked_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Hold reset, then release it on a falling edge.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result sink: drive ready on the falling edge. On request, hold ready low
  // for a long counted stretch so the command queue fills and input stalls.
  initial begin
    forever begin
      @(negedge clk_i);
      if (holdoff_asks != holdoff_done) begin
        holdoff_done++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check every result beat taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(out_data_o);
  end

  function automatic in_item_t req(logic [2:0] m, logic [7:0] d, logic s, logic [6:0] l,
                                   logic p);
    in_item_t it;
    it.mode         = m;
    it.data_byte    = d;
    it.chunk_start  = s;
    it.chunk_length = l;
    it.partial      = p;
    return it;
  endfunction

  // Offer one beat: idle at random first, then hold valid and payload until
  // taken. Returns right after the accepting rising edge.
  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  // Drop valid and wait until every predicted beat is out, then let the
  // pipeline settle so no write still sits in the command queue.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [10:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.configure(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send an enqueue chunk with random bytes; cut it short when asked, which
  // leaves it open for the next request to close.
  task automatic send_chunk(logic [6:0] len, logic part, logic cut, output int unsigned sent);
    int unsigned nbytes;
    nbytes = (len > MAX_CHUNK_DEF) ? MAX_CHUNK_DEF : int'(len);
    if (nbytes == 0) nbytes = 1;
    if (cut && nbytes > 1) nbytes = $urandom_range(1, nbytes - 1);
    send_item(req(MODE_ENQ, 8'($urandom_range(255)), 1'b1, len, part));
    for (int i = 1; i < nbytes; i++)
      send_item(req(MODE_ENQ, 8'($urandom_range(255)), 1'b0, 7'($urandom_range(127)),
                    1'($urandom_range(1))));
    sent = nbytes;
  endtask

  // Mostly well-formed chunks and reads with random content; a share of cut
  // chunks, stray bytes and reserved modes as noise.
  task automatic run_random(int unsigned n_items);
    int unsigned sent, pick, got;
    logic [6:0]  len;
    logic [2:0]  m;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 12));
        send_chunk(len, 1'($urandom_range(1)), $urandom_range(9) == 0, got);
        sent += got;
      end else if (pick < 82) begin
        if (pick < 60)      m = MODE_DEQ;
        else if (pick < 72) m = MODE_PEEK;
        else                m = MODE_DROP;
        len = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(16));
        send_item(req(m, 8'($urandom_range(255)), 1'($urandom_range(1)), len,
                      1'($urandom_range(1))));
        sent++;
      end else if (pick < 86) begin
        send_item(req(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      7'($urandom_range(127)), 1'($urandom_range(1))));
        sent++;
      end else if (pick < 93) begin
        // Stray byte: appended only if a cut chunk is still open.
        send_item(req(MODE_ENQ, 8'($urandom_range(255)), 1'b0, 7'($urandom_range(127)),
                      1'($urandom_range(1))));
      end else begin
        case ($urandom_range(2))
          0:       m = MODE_RSVD5;
          1:       m = MODE_RSVD6;
          default: m = MODE_RSVD7;
        endcase
        send_item(req(m, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      7'($urandom_range(127)), 1'($urandom_range(1))));
      end
    end
  endtask

  initial begin
    int unsigned dummy;
    @(posedge rst_ni);

    // Directed: a six-byte ring to reach full, refusal, cut-to-fit and wrap.
    write_capacity(11'd6);
    send_item(req(MODE_CLEAR, 8'h00, 1'b0, 7'd0, 1'b0));
    send_item(req(MODE_ENQ, 8'hFF, 1'b1, 7'd0, 1'b0));    // empty chunk, byte dropped
    send_item(req(MODE_ENQ, 8'h11, 1'b0, 7'd0, 1'b0));    // no open chunk, ignored
    send_item(req(MODE_ENQ, 8'h00, 1'b1, 7'd4, 1'b0));
    send_item(req(MODE_ENQ, 8'hFF, 1'b0, 7'd0, 1'b0));
    send_item(req(MODE_ENQ, 8'hA5, 1'b0, 7'd0, 1'b0));
    send_item(req(MODE_ENQ, 8'h5A, 1'b0, 7'd0, 1'b0));
    send_item(req(MODE_PEEK, 8'h00, 1'b0, 7'd127, 1'b0)); // too long, refused
    send_item(req(MODE_PEEK, 8'h00, 1'b0, 7'd127, 1'b1)); // cut to what is held
    send_chunk(7'd4, 1'b0, 1'b0, dummy);                  // does not fit, refused whole
    send_chunk(7'd4, 1'b1, 1'b0, dummy);                  // cut to free space, wraps
    send_item(req(MODE_DEQ, 8'h00, 1'b0, 7'd3, 1'b0));
    send_item(req(MODE_ENQ, 8'h3C, 1'b1, 7'd3, 1'b0));    // left open
    send_item(req(MODE_PEEK, 8'h00, 1'b0, 7'd4, 1'b0));   // closes chunk, reads across wrap
    send_item(req(MODE_DROP, 8'h00, 1'b0, 7'd127, 1'b0)); // drop is always partial
    send_item(req(MODE_DEQ, 8'h00, 1'b0, 7'd0, 1'b0));    // zero-length read
    send_item(req(MODE_DEQ, 8'h00, 1'b0, 7'd5, 1'b1));    // empty ring
    send_item(req(MODE_RSVD5, 8'h00, 1'b0, 7'd0, 1'b0));
    send_item(req(MODE_RSVD6, 8'h00, 1'b1, 7'd1, 1'b1));
    send_item(req(MODE_RSVD7, 8'hFF, 1'b1, 7'd127, 1'b1));
    wait_drained();

    // Directed: zero capacity refuses everything but clear.
    write_capacity(11'd0);
    send_chunk(7'd2, 1'b1, 1'b0, dummy);
    send_item(req(MODE_PEEK, 8'h00, 1'b0, 7'd3, 1'b1));
    send_item(req(MODE_DROP, 8'h00, 1'b0, 7'd3, 1'b0));
    send_item(req(MODE_CLEAR, 8'h00, 1'b0, 7'd0, 1'b0));
    wait_drained();

    // Full size ring, streaming with no idling at all.
    write_capacity(11'd1024);
    steady = 1'b1;
    run_random(60);
    wait_drained();
    steady = 1'b0;

    // Small ring that fills often; stall the receiver for a long stretch.
    write_capacity(11'd37);
    holdoff_asks++;
    run_random(80);
    wait_drained();

    // Capacity above the store size; pause the sender halfway until all is out.
    write_capacity(11'd2047);
    run_random(20);
    wait_drained();
    run_random(20);
    wait_drained();

    write_capacity(11'd1);
    run_random(30);
    wait_drained();

    write_capacity(11'd0);
    run_random(15);
    wait_drained();

    write_capacity(11'd300);
    run_random(40);
    wait_drained();

    if (sb.fails == 0 && sb.expected_beats.size() == 0) begin
      $display("byte_ring_buffer_chunked_top test passed");
    end else begin
      $display("byte_ring_buffer_chunked_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("byte_ring_buffer_chunked_top test failed");
    $finish;
  end

endmodule

[files.f]
src/brbc_pkg.sv
src/brbc_front.sv
src/brbc_cmd_queue.sv
src/brbc_back.sv
src/byte_ring_buffer_chunked_top.sv
src/brbc_checker.sv
dv/tb.sv
